@@ rtl/core/lzwd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and types for the GIF LZW decoder unit.
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam int MAX_CODE_BITS = 12;
	localparam int DICT_DEPTH    = 1 << MAX_CODE_BITS;
	localparam int DICT_AW       = MAX_CODE_BITS;
	localparam int CNT_W         = MAX_CODE_BITS + 1;
	localparam int BUF_BITS      = 24;

	localparam logic [2:0] ST_NEED_DATA = 3'd0;
	localparam logic [2:0] ST_PIXEL     = 3'd1;
	localparam logic [2:0] ST_END       = 3'd2;
	localparam logic [2:0] ST_PUSH_OK   = 3'd3;
	localparam logic [2:0] ST_PUSH_REF  = 3'd4;
	localparam logic [2:0] ST_INVALID   = 3'd5;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	typedef struct packed {
		logic       is_pull;
		logic [7:0] byte_in;
	} lzwd_item_t;

endpackage
`default_nettype wire

@@ rtl/core/lzwd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_front
// Accepts items, tags them as push or pull and queues them (two entries).
// ----------------------------------------------------------------------------
module lzwd_front
	import lzwd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       func,
	input  wire logic [7:0] byte_in,
	output logic            q_valid,
	output lzwd_item_t      q_item,
	input  wire logic       q_pop
);

	lzwd_item_t  ent_q [2];
	logic        rd_ptr_q, wr_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].is_pull <= (func == FUNC_PULL);
			ent_q[wr_ptr_q].byte_in <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)  wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/lzwd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_back
// Executes queued items: bit buffer, code extraction, dictionary and stack.
// ----------------------------------------------------------------------------
module lzwd_back
	import lzwd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_data,
	input  wire logic       q_valid,
	input  lzwd_item_t      q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      pixel_index,
	output logic [2:0]      status,
	output logic [CNT_W-1:0] stack_level
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PULL  = 3'd1;
	localparam logic [2:0] S_POPRD = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_WREAD = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]          state_q;
	logic [3:0]          mcs_q;
	logic [BUF_BITS-1:0] buf_q;
	logic [4:0]          bcnt_q;
	logic [3:0]          width_q;
	logic [CNT_W-1:0]    next_q;
	logic [CNT_W-1:0]    scnt_q;
	logic [DICT_AW-1:0]  prev_code_q;
	logic [7:0]          prev_first_q;
	logic                after_clear_q;
	logic                finished_q;
	logic [DICT_AW-1:0]  cur_q;
	logic [DICT_AW-1:0]  code_q;
	logic [7:0]          pix_q;
	logic [2:0]          stat_q;

	logic [DICT_AW-1:0]  prefix_mem [DICT_DEPTH];
	logic [7:0]          suffix_mem [DICT_DEPTH];
	logic [7:0]          stack_mem  [DICT_DEPTH];
	logic [DICT_AW-1:0]  pre_rd;
	logic [7:0]          suf_rd;
	logic [7:0]          stk_rd;

	logic [3:0]          eff;
	logic [8:0]          clear_c;
	logic [DICT_AW-1:0]  mask;
	logic [DICT_AW-1:0]  code_c;
	logic                stk_we;
	logic [7:0]          stk_wd;
	logic                dict_we;
	logic                dict_room;
	logic                stk_room;

	always_comb begin
		if (mcs_q < 4'd2)      eff = 4'd2;
		else if (mcs_q > 4'd8) eff = 4'd8;
		else                   eff = mcs_q;
	end
	assign clear_c   = 9'd1 << eff;
	assign mask      = DICT_AW'((13'd1 << width_q) - 13'd1);
	assign code_c    = buf_q[DICT_AW-1:0] & mask;
	assign dict_room = (next_q < CNT_W'(DICT_DEPTH));
	assign stk_room  = (scnt_q < CNT_W'(DICT_DEPTH));

	assign q_pop       = (state_q == S_IDLE) && q_valid && !cfg_we;
	assign out_valid   = (state_q == S_OUT);
	assign pixel_index = pix_q;
	assign status      = stat_q;
	assign stack_level = scnt_q;

	// stack write enable and source, and dictionary write enable, by state
	always_comb begin
		stk_we  = 1'b0;
		stk_wd  = suf_rd;
		dict_we = 1'b0;
		case (state_q)
			S_PULL: begin
				if (scnt_q == '0 && !finished_q && {1'b0, bcnt_q} >= {2'b0, width_q}
				    && code_c != DICT_AW'(clear_c) && code_c != DICT_AW'(clear_c) + 1'b1
				    && !after_clear_q && {1'b0, code_c} == next_q && dict_room) begin
					stk_we = stk_room;
					stk_wd = prev_first_q;
				end
			end
			S_WREAD: stk_we = 1'b1;
			S_WALK: begin
				if (!(cur_q >= {3'b0, clear_c} && stk_room)) begin
					stk_we  = stk_room;
					stk_wd  = cur_q[7:0];
					dict_we = dict_room;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		pre_rd <= prefix_mem[cur_q];
		suf_rd <= suffix_mem[cur_q];
		if (dict_we) begin
			prefix_mem[next_q[DICT_AW-1:0]] <= prev_code_q;
			suffix_mem[next_q[DICT_AW-1:0]] <= cur_q[7:0];
		end
	end

	always_ff @(posedge clk) begin
		stk_rd <= stack_mem[scnt_q[DICT_AW-1:0] - 1'b1];
		if (stk_we) stack_mem[scnt_q[DICT_AW-1:0]] <= stk_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mcs_q         <= 4'd8;
			buf_q         <= '0;
			bcnt_q        <= '0;
			width_q       <= 4'd9;
			next_q        <= CNT_W'(258);
			scnt_q        <= '0;
			prev_code_q   <= '0;
			prev_first_q  <= '0;
			after_clear_q <= 1'b1;
			finished_q    <= 1'b0;
			cur_q         <= '0;
			code_q        <= '0;
			pix_q         <= '0;
			stat_q        <= ST_NEED_DATA;
		end else begin
			if (stk_we) scnt_q <= scnt_q + 1'b1;
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						// clamp of the new value, then a dictionary reset
						mcs_q         <= cfg_data;
						width_q       <= ((cfg_data < 4'd2) ? 4'd2 :
						                  (cfg_data > 4'd8) ? 4'd8 : cfg_data) + 4'd1;
						next_q        <= CNT_W'(((cfg_data < 4'd2) ? 13'd4 :
						                  (cfg_data > 4'd8) ? 13'd256 :
						                  (13'd1 << cfg_data)) + 13'd2);
						after_clear_q <= 1'b1;
					end else if (q_valid) begin
						pix_q <= '0;
						if (q_item.is_pull) begin
							state_q <= S_PULL;
						end else begin
							state_q <= S_OUT;
							if (bcnt_q > 5'd16) begin
								stat_q <= ST_PUSH_REF;
							end else begin
								buf_q  <= buf_q | (BUF_BITS'(q_item.byte_in) << bcnt_q);
								bcnt_q <= bcnt_q + 5'd8;
								stat_q <= ST_PUSH_OK;
							end
						end
					end
				end
				S_PULL: begin
					if (scnt_q != '0) begin
						scnt_q  <= scnt_q - 1'b1;
						state_q <= S_POPRD;
					end else if (finished_q) begin
						stat_q  <= ST_END;
						state_q <= S_OUT;
					end else if ({1'b0, bcnt_q} < {2'b0, width_q}) begin
						stat_q  <= ST_NEED_DATA;
						state_q <= S_OUT;
					end else begin
						buf_q  <= buf_q >> width_q;
						bcnt_q <= bcnt_q - {1'b0, width_q};
						code_q <= code_c;
						if (code_c == DICT_AW'(clear_c)) begin
							width_q       <= eff + 4'd1;
							next_q        <= CNT_W'(clear_c) + CNT_W'(2);
							after_clear_q <= 1'b1;
						end else if (code_c == DICT_AW'(clear_c) + 1'b1) begin
							finished_q <= 1'b1;
							stat_q     <= ST_END;
							state_q    <= S_OUT;
						end else if (after_clear_q) begin
							if (code_c >= {3'b0, clear_c}) begin
								stat_q <= ST_INVALID;
							end else begin
								prev_code_q   <= code_c;
								prev_first_q  <= code_c[7:0];
								after_clear_q <= 1'b0;
								pix_q         <= code_c[7:0];
								stat_q        <= ST_PIXEL;
							end
							state_q <= S_OUT;
						end else if ({1'b0, code_c} < next_q) begin
							cur_q   <= code_c;
							state_q <= S_WALK;
						end else if ({1'b0, code_c} == next_q && dict_room) begin
							// code not yet defined: previous string plus its first symbol
							cur_q   <= prev_code_q;
							state_q <= S_WALK;
						end else begin
							stat_q  <= ST_INVALID;
							state_q <= S_OUT;
						end
					end
				end
				S_POPRD: begin
					pix_q   <= stk_rd;
					stat_q  <= ST_PIXEL;
					state_q <= S_OUT;
				end
				S_WALK: begin
					if (cur_q >= {3'b0, clear_c} && stk_room) begin
						state_q <= S_WREAD;
					end else begin
						if (dict_room) begin
							next_q <= next_q + 1'b1;
							if (next_q + 1'b1 == (CNT_W'(1) << width_q)
							    && width_q < 4'(MAX_CODE_BITS))
								width_q <= width_q + 4'd1;
						end
						prev_code_q  <= code_q;
						prev_first_q <= cur_q[7:0];
						state_q      <= S_PULL;
					end
				end
				S_WREAD: begin
					cur_q   <= pre_rd;
					state_q <= S_WALK;
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/gif_lzw_decoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gif_lzw_decoder_unit
// Steps: a push goes S_IDLE, S_OUT; a pull from the stack goes S_IDLE, S_PULL,
// S_POPRD, S_OUT; a code decode first walks its string in the dictionary (S_WALK,
// S_WREAD). The back end takes one item at a time; front queue holds 2 items.
// Reset: asynchronous active low; control clears, memories are undefined.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_unit
	import lzwd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       func,
	input  wire logic [7:0] byte_in,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      pixel_index,
	output logic [2:0]      status
);

	logic             q_valid, q_pop;
	lzwd_item_t       q_item;
	logic [CNT_W-1:0] stack_level;

	lzwd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.byte_in  (byte_in),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	lzwd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.status      (status),
		.stack_level (stack_level)
	);

`ifndef SYNTH
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_INVALID))
		else $error("status code out of range");

	a_pix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_PIXEL) |-> (pixel_index == 8'd0))
		else $error("pixel index not zero on non-pixel item");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stack_level <= CNT_W'(DICT_DEPTH))
		else $error("string stack overflow");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

@@ tb/sv/gif_lzw_decoder_unit_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gif_lzw_decoder_unit_tb
// Self-checking bench for the GIF LZW decoder unit. A built-in encoder packs
// legal code streams (clears, literals, known strings, not-yet-defined codes,
// some invalid codes) into bytes. These are pushed and pulled with random
// gaps and output stalls. A bit-exact predictor of the decoder gives the
// expected pixel and status of every item, and each result is checked.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_unit_tb
	import lzwd_pkg::*;
();

	typedef struct {
		logic [7:0] pix;
		logic [2:0] st;
	} pixel_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic       func;
	logic [7:0] byte_in;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] pixel_index;
	logic [2:0] status;

	gif_lzw_decoder_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .byte_in(byte_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_index(pixel_index), .status(status)
	);

	// decoder predictor state
	logic [3:0]  p_size;
	logic [11:0] p_prefix [DICT_DEPTH];
	logic [7:0]  p_suffix [DICT_DEPTH];
	logic [7:0]  p_stack  [DICT_DEPTH];
	int          p_sp, p_buf, p_bcnt, p_cw, p_next, p_prev, p_first;
	bit          p_after, p_fin;

	// encoder state
	byte unsigned code_bytes[$];
	longint      enc_acc;
	int          enc_nbits, enc_size, enc_w, enc_next;
	bit          enc_after;

	pixel_result_t pixel_q[$];
	int  n_items, n_err, n_cfg;
	int  n_status [8];
	bit  tx_idle, rx_idle;
	int  stall_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("gif_lzw_decoder_unit_tb: FAIL");
		$finish;
	end

	function automatic int eff_size(input logic [3:0] v);
		if (v < 2) return 2;
		if (v > 8) return 8;
		return v;
	endfunction

	function void p_clear();
		p_cw    = eff_size(p_size) + 1;
		p_next  = (1 << eff_size(p_size)) + 2;
		p_after = 1'b1;
	endfunction

	function void p_push(input int v);
		if (p_sp < DICT_DEPTH) begin
			p_stack[p_sp] = v[7:0];
			p_sp++;
		end
	endfunction

	// stack the string of a code in reverse, give back its first symbol
	function int p_walk(input int c, input int clr);
		c = c & (DICT_DEPTH - 1);
		while (c >= clr && p_sp < DICT_DEPTH) begin
			p_push(p_suffix[c]);
			c = p_prefix[c];
		end
		p_push(c);
		return c & 8'hFF;
	endfunction

	task automatic decode_item(input logic f, input logic [7:0] b,
			output logic [7:0] pix, output logic [2:0] st);
		int clr, code, first;
		bit go;
		pix = 8'd0;
		st  = ST_NEED_DATA;
		if (f == FUNC_PUSH) begin
			if (p_bcnt + 8 > BUF_BITS) begin
				st = ST_PUSH_REF;
			end else begin
				p_buf  = (p_buf | (int'(b) << p_bcnt)) & 32'hFF_FFFF;
				p_bcnt += 8;
				st     = ST_PUSH_OK;
			end
		end else begin
			go = 1'b1;
			while (go) begin
				go  = 1'b0;
				clr = 1 << eff_size(p_size);
				if (p_sp > 0) begin
					p_sp--;
					pix = p_stack[p_sp];
					st  = ST_PIXEL;
				end else if (p_fin) begin
					st = ST_END;
				end else if (p_bcnt < p_cw) begin
					st = ST_NEED_DATA;
				end else begin
					code   = p_buf & ((1 << p_cw) - 1);
					p_buf  = p_buf >> p_cw;
					p_bcnt -= p_cw;
					if (code == clr) begin
						p_clear();
						go = 1'b1;
					end else if (code == clr + 1) begin
						p_fin = 1'b1;
						st    = ST_END;
					end else if (p_after) begin
						if (code >= clr) begin
							st = ST_INVALID;
						end else begin
							p_prev  = code;
							p_first = code;
							p_after = 1'b0;
							pix     = code[7:0];
							st      = ST_PIXEL;
						end
					end else if (code < p_next || (code == p_next && p_next < DICT_DEPTH)) begin
						if (code < p_next) begin
							first = p_walk(code, clr);
						end else begin
							p_push(p_first);
							first = p_walk(p_prev, clr);
						end
						if (p_next < DICT_DEPTH) begin
							p_prefix[p_next] = p_prev[11:0];
							p_suffix[p_next] = first[7:0];
							p_next++;
							if (p_next == (1 << p_cw) && p_cw < MAX_CODE_BITS)
								p_cw++;
						end
						p_prev  = code;
						p_first = first;
						go      = 1'b1;
					end else begin
						st = ST_INVALID;
					end
				end
			end
		end
		n_status[st]++;
	endtask

	// encoder: pack one code LSB first and track the dictionary as the decoder will
	task automatic emit_code(input int code);
		int clr;
		clr = 1 << enc_size;
		enc_acc   = enc_acc | (longint'(code) << enc_nbits);
		enc_nbits += enc_w;
		while (enc_nbits >= 8) begin
			code_bytes.insert(code_bytes.size(), enc_acc[7:0]);
			enc_acc   = enc_acc >> 8;
			enc_nbits -= 8;
		end
		if (code == clr) begin
			enc_w     = enc_size + 1;
			enc_next  = clr + 2;
			enc_after = 1'b1;
		end else if (enc_after) begin
			if (code < clr)
				enc_after = 1'b0;
		end else if (code < enc_next || (code == enc_next && enc_next < DICT_DEPTH)) begin
			if (enc_next < DICT_DEPTH) begin
				enc_next++;
				if (enc_next == (1 << enc_w) && enc_w < MAX_CODE_BITS)
					enc_w++;
			end
		end
	endtask

	// fill_mode favours literals so that the dictionary fills quickly
	function automatic int pick_code(input bit fill_mode);
		int clr, r, top;
		clr = 1 << enc_size;
		r   = $urandom_range(0, 99);
		top = (1 << enc_w) - 1;
		if (fill_mode)
			r = (r < 90) ? 40 : 80;
		if (enc_after)
			return (r < 8) ? $urandom_range(clr + 2, top) : $urandom_range(0, clr - 1);
		if (r < 4)
			return clr;
		if (r < 8 && enc_next + 1 <= top)
			return $urandom_range(enc_next + 1, top);
		if (r < 20 && enc_next < DICT_DEPTH)
			return enc_next;
		if (r >= 55 && enc_next > clr + 2)
			return $urandom_range(clr + 2, enc_next - 1);
		return $urandom_range(0, clr - 1);
	endfunction

	// pad the stream to a byte edge with legal codes so a size change stays aligned
	task automatic align_stream();
		while (enc_nbits != 0) begin
			if (enc_w == MAX_CODE_BITS && enc_w % 2 == 0)
				emit_code(1 << enc_size);
			else
				emit_code($urandom_range(0, (1 << enc_size) - 1));
		end
	endtask

	task automatic report_err(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		n_err++;
	endtask

	task automatic send_item(input logic f, input logic [7:0] b, output logic [2:0] st);
		int gap;
		logic [7:0] pix;
		pixel_result_t res;
		gap = tx_idle ? $urandom_range(0, 11) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		byte_in  <= b;
		do @(posedge clk); while (in_stall);
		decode_item(f, b, pix, st);
		res.pix = pix;
		res.st  = st;
		pixel_q.insert(pixel_q.size(), res);
		n_items++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// push pending bytes and pull pixels at random until the decoder runs dry
	task automatic feed_stream();
		logic [2:0] st;
		bit done;
		done    = 1'b0;
		tx_idle = $urandom_range(0, 3) != 0;
		rx_idle = $urandom_range(0, 3) != 0;
		while (!done) begin
			if (code_bytes.size() > 0 && $urandom_range(0, 1)) begin
				send_item(FUNC_PUSH, code_bytes[0], st);
				if (st == ST_PUSH_OK)
					void'(code_bytes.pop_front());
			end else begin
				send_item(FUNC_PULL, 8'($urandom_range(0, 255)), st);
				if (st == ST_END) begin
					// nothing after the end code is ever decoded
					code_bytes.delete();
					done = 1'b1;
				end else if (code_bytes.size() == 0 && st == ST_NEED_DATA) begin
					done = 1'b1;
				end
			end
		end
	endtask

	task automatic set_size(input logic [3:0] v);
		align_stream();
		feed_stream();
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		p_size   = v;
		p_clear();
		enc_size  = eff_size(v);
		enc_w     = enc_size + 1;
		enc_next  = (1 << enc_size) + 2;
		enc_after = 1'b1;
		n_cfg++;
	endtask

	task automatic test_directed();
		logic [2:0] st;
		send_item(FUNC_PULL, 8'h00, st);
		emit_code(256);
		emit_code(0);
		emit_code(255);
		emit_code(259);		// not yet defined
		emit_code(258);
		emit_code(400);		// above next free code
		emit_code(256);
		emit_code(300);		// not a literal after clear
		emit_code(7);
		// fourth push finds the buffer full
		repeat (4) begin
			send_item(FUNC_PUSH, code_bytes[0], st);
			if (st == ST_PUSH_OK)
				void'(code_bytes.pop_front());
		end
		feed_stream();
	endtask

	task automatic test_size_extremes();
		logic [3:0] sizes [6];
		sizes = '{4'd0, 4'd15, 4'd2, 4'd8, 4'd1, 4'd9};
		foreach (sizes[i]) begin
			set_size(sizes[i]);
			repeat (12) emit_code(pick_code(1'b0));
			feed_stream();
		end
	endtask

	// smallest code size, so the code width steps up several times
	task automatic test_width_growth();
		set_size(4'd2);
		repeat (3) begin
			repeat (40) emit_code(pick_code(1'b1));
			feed_stream();
		end
	endtask

	task automatic test_random();
		int stop_at;
		// overall item budget for the run
		stop_at = 950;
		while (n_items < stop_at) begin
			if ($urandom_range(0, 3) == 0)
				set_size(4'($urandom_range(0, 15)));
			repeat ($urandom_range(10, 60)) emit_code(pick_code(1'b0));
			feed_stream();
		end
	endtask

	task automatic test_end();
		logic [2:0] st;
		emit_code((1 << enc_size) + 1);
		align_stream();
		feed_stream();
		repeat (30)
			send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), st);
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			stall_left <= 0;
		else if (out_valid && !out_stall)
			stall_left <= rx_idle ? $urandom_range(0, 11) : 0;
		else if (stall_left > 0)
			stall_left <= stall_left - 1;
	end

	always @(negedge clk)
		out_stall <= (stall_left != 0);

	always @(posedge clk) begin
		pixel_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				report_err($sformatf("unexpected item status %0d", status));
			end else begin
				e = pixel_q.pop_front();
				if (status !== e.st)
					report_err($sformatf("status %0d, want %0d", status, e.st));
				if (pixel_index !== e.pix)
					report_err($sformatf("pixel %0d, want %0d", pixel_index, e.pix));
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_data  = 4'd8;
		in_valid  = 1'b0;
		func      = FUNC_PUSH;
		byte_in   = 8'd0;
		out_stall = 1'b0;
		stall_left = 0;
		tx_idle   = 1'b1;
		rx_idle   = 1'b1;
		n_items = 0; n_err = 0; n_cfg = 0;
		foreach (n_status[i]) n_status[i] = 0;
		foreach (p_prefix[i]) begin
			p_prefix[i] = '0;
			p_suffix[i] = '0;
			p_stack[i]  = '0;
		end
		p_size = 4'd8;
		p_sp = 0; p_buf = 0; p_bcnt = 0; p_prev = 0; p_first = 0; p_fin = 1'b0;
		p_clear();
		enc_acc = 0; enc_nbits = 0; enc_size = 8; enc_w = 9; enc_next = 258;
		enc_after = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_size_extremes();
		test_width_growth();
		test_random();
		test_end();

		drain();
		repeat (30) @(posedge clk);
		$display("%0d items, %0d size writes; %0d pixels, %0d invalid codes, %0d refused pushes",
			n_items, n_cfg, n_status[ST_PIXEL], n_status[ST_INVALID], n_status[ST_PUSH_REF]);
		$display("needs-data %0d, end %0d, mismatches %0d",
			n_status[ST_NEED_DATA], n_status[ST_END], n_err);
		if (n_err == 0)
			$display("gif_lzw_decoder_unit_tb: PASS");
		else
			$display("gif_lzw_decoder_unit_tb: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
